### src/prrr_pkg.sv
`timescale 1ns / 1ps

package prrr_pkg;

   // default sizes of the peer table and the handle map
   localparam int PEERS_DEF   = 16;
   localparam int HANDLES_DEF = 1024;

   // fixed field widths
   localparam int PID_W    = 4;
   localparam int HANDLE_W = 16;

   // operation codes
   typedef enum logic [1:0] {
      KIND_BIND = 2'd0,
      KIND_DOWN = 2'd1,
      KIND_GET  = 2'd2,
      KIND_PICK = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [PID_W-1:0]      peer_id;
      logic [HANDLE_W-1:0]   handle;
   } req_word_type;

   typedef struct packed {
      logic                  status;
      logic [PID_W-1:0]      chosen_peer;
      logic [HANDLE_W-1:0]   peer_handle;
   } rsp_word_type;

endpackage

### src/peer_registry_round_robin.sv
`timescale 1ns / 1ps

// A request word is accepted only while idle, then registered with the memory reads; the
// execute step does one read-modify-write of the handle map and peer handle memories and
// loads the result register, waiting on a stalled result; only then is a new word taken.
// Reset: peer health, pick candidates and the last-pick pointer clear at once; the handle
// map is then swept to zero one entry a cycle, with req_stall held high.
module peer_registry_round_robin
   import prrr_pkg::*;
#(
   parameter int PEERS   = PEERS_DEF,
   parameter int HANDLES = HANDLES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int P_W = (PEERS > 1) ? $clog2(PEERS) : 1;
   localparam int H_W = (HANDLES > 1) ? $clog2(HANDLES) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // handle map: owning peer per handle, zero when unmapped
   logic [PID_W-1:0]    owner_mem [HANDLES];
   // handle bound to each peer
   logic [HANDLE_W-1:0] conn_mem  [PEERS];

   state_type           state_ff, state_in;
   logic [H_W-1:0]      clr_addr_ff, clr_addr_in;
   req_word_type        op_ff;
   logic [PID_W-1:0]    owner_rd_ff;
   logic [HANDLE_W-1:0] conn_rd_ff;
   logic [PEERS-1:0]    peer_ok_ff, peer_ok_in;
   logic [PEERS-1:0]    cand_ff, cand_in;
   logic [P_W-1:0]      last_pick_ff, last_pick_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                accept;
   logic                done;
   logic [H_W-1:0]      req_hidx;
   logic [P_W-1:0]      req_pidx;
   logic                op_pid_ok;
   logic                op_h_ok;
   logic [P_W-1:0]      op_pidx;
   logic [H_W-1:0]      op_hidx;
   logic [P_W-1:0]      own_idx;
   logic                owner_we;
   logic [H_W-1:0]      owner_waddr;
   logic [PID_W-1:0]    owner_wdata;
   logic                conn_we;
   logic                hi_hit, lo_hit;
   logic [P_W-1:0]      hi_idx, lo_idx;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign done      = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign req_hidx = H_W'(req_word.handle);
   assign req_pidx = P_W'(req_word.peer_id);

   // decode the held operation
   assign op_pid_ok = (op_ff.peer_id != '0) && (32'(op_ff.peer_id) < 32'(PEERS));
   assign op_h_ok   = (op_ff.handle != '0) && (32'(op_ff.handle) < 32'(HANDLES));
   assign op_pidx   = P_W'(op_ff.peer_id);
   assign op_hidx   = H_W'(op_ff.handle);
   assign own_idx   = P_W'(owner_rd_ff);

   // rotating search: first candidate above the last pick, else the lowest one
   always_comb begin
      hi_hit = 1'b0;
      lo_hit = 1'b0;
      hi_idx = '0;
      lo_idx = '0;
      for (int j = PEERS - 1; j >= 1; j--) begin
         if (cand_ff[j]) begin
            lo_hit = 1'b1;
            lo_idx = P_W'(j);
            if (j > int'(last_pick_ff)) begin
               hi_hit = 1'b1;
               hi_idx = P_W'(j);
            end
         end
      end
   end

   // write ports: sweep during clear, else write back from the execute step
   always_comb begin
      owner_we    = 1'b0;
      owner_waddr = op_hidx;
      owner_wdata = '0;
      conn_we     = 1'b0;
      if (state_ff == ST_CLEAR) begin
         owner_we    = 1'b1;
         owner_waddr = clr_addr_ff;
      end else if (done) begin
         case (op_ff.kind)
            KIND_BIND: begin
               conn_we     = op_pid_ok;
               owner_we    = op_pid_ok && op_h_ok;
               owner_wdata = op_ff.peer_id;
            end
            KIND_DOWN: begin
               owner_we = op_h_ok;
            end
            default: begin
               owner_we = 1'b0;
            end
         endcase
      end
   end

   // handle map memory
   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[owner_waddr] <= owner_wdata;
      end
      if (accept) begin
         owner_rd_ff <= owner_mem[req_hidx];
      end
   end

   // peer handle memory
   always_ff @(posedge clock) begin
      if (conn_we) begin
         conn_mem[op_pidx] <= op_ff.handle;
      end
      if (accept) begin
         conn_rd_ff <= conn_mem[req_pidx];
      end
   end

   // next state and results
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      peer_ok_in   = peer_ok_ff;
      cand_in      = cand_ff;
      last_pick_in = last_pick_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + H_W'(1);
            if (32'(clr_addr_ff) == 32'(HANDLES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{status: 1'b1, chosen_peer: '0, peer_handle: '0};
               unique case (op_ff.kind)
                  KIND_BIND: begin
                     if (op_pid_ok) begin
                        peer_ok_in[op_pidx] = 1'b1;
                        cand_in[op_pidx]    = (op_ff.handle != '0);
                        rsp_word_in.status  = 1'b0;
                     end
                  end
                  KIND_DOWN: begin
                     if (op_h_ok) begin
                        if (owner_rd_ff != '0) begin
                           peer_ok_in[own_idx] = 1'b0;
                           cand_in[own_idx]    = 1'b0;
                        end
                        rsp_word_in.status = 1'b0;
                     end
                  end
                  KIND_GET: begin
                     if (op_pid_ok && peer_ok_ff[op_pidx]) begin
                        rsp_word_in.status      = 1'b0;
                        rsp_word_in.peer_handle = conn_rd_ff;
                     end
                  end
                  KIND_PICK: begin
                     if (hi_hit) begin
                        last_pick_in            = hi_idx;
                        rsp_word_in.status      = 1'b0;
                        rsp_word_in.chosen_peer = PID_W'(hi_idx);
                     end else if (lo_hit) begin
                        last_pick_in            = lo_idx;
                        rsp_word_in.status      = 1'b0;
                        rsp_word_in.chosen_peer = PID_W'(lo_idx);
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         peer_ok_ff   <= '0;
         cand_ff      <= '0;
         last_pick_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         peer_ok_ff   <= peer_ok_in;
         cand_ff      <= cand_in;
         last_pick_ff <= last_pick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      if (accept) begin
         op_ff <= req_word;
      end
   end

endmodule

### tb/sv/peer_registry_round_robin_tb.sv
`timescale 1ns / 1ps

module peer_registry_round_robin_tb;
   import prrr_pkg::*;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int RANDOM_WORDS = 1850;
   localparam int QUIET_TAIL   = 150;
   localparam int DRAIN_CYCLES = 20;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // registry image kept by the testbench
   logic [HANDLE_W-1:0] peer_handle_tbl [PEERS_DEF];
   logic                peer_up         [PEERS_DEF];
   logic                handle_mapped   [HANDLES_DEF];
   logic [PID_W-1:0]    handle_owner    [HANDLES_DEF];
   logic [PID_W-1:0]    last_chosen;

   req_word_type req_backlog [$];
   rsp_word_type due_rsp [$];
   rsp_word_type want;
   int           cycle_cnt  = 0;
   int           fail_count = 0;
   int           req_gap    = 0;
   int           stall_left = 0;

   peer_registry_round_robin i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // no idling once the backlog runs low
   function automatic logic tail_quiet();
      return (req_backlog.size() < QUIET_TAIL);
   endfunction

   // apply one request word to the registry image and return the result it gives
   function automatic rsp_word_type registry_apply(req_word_type w);
      rsp_word_type r;
      int           idx;
      logic         found;
      logic [PID_W-1:0] own;
      r.status      = 1'b1;
      r.chosen_peer = '0;
      r.peer_handle = '0;
      found         = 1'b0;
      case (w.kind)
         KIND_BIND: begin
            if (w.peer_id != 0) begin
               peer_handle_tbl[w.peer_id] = w.handle;
               peer_up[w.peer_id]         = 1'b1;
               if (w.handle != 0 && w.handle < HANDLES_DEF) begin
                  handle_mapped[w.handle] = 1'b1;
                  handle_owner[w.handle]  = w.peer_id;
               end
               r.status = 1'b0;
            end
         end
         KIND_DOWN: begin
            if (w.handle != 0 && w.handle < HANDLES_DEF) begin
               if (handle_mapped[w.handle]) begin
                  own = handle_owner[w.handle];
                  if (own != 0) begin
                     peer_handle_tbl[own] = '0;
                     peer_up[own]         = 1'b0;
                  end
               end
               handle_mapped[w.handle] = 1'b0;
               handle_owner[w.handle]  = '0;
               r.status = 1'b0;
            end
         end
         KIND_GET: begin
            if (w.peer_id != 0 && peer_up[w.peer_id]) begin
               r.peer_handle = peer_handle_tbl[w.peer_id];
               r.status      = 1'b0;
            end
         end
         default: begin
            // rotate from the peer after the last one picked, peer 0 never takes part
            for (int i = 1; i < PEERS_DEF; i++) begin
               idx = ((int'(last_chosen) + i - 1) % (PEERS_DEF - 1)) + 1;
               if (!found && peer_up[idx] && peer_handle_tbl[idx] != 0) begin
                  found         = 1'b1;
                  last_chosen   = idx[PID_W-1:0];
                  r.chosen_peer = idx[PID_W-1:0];
                  r.status      = 1'b0;
               end
            end
         end
      endcase
      return r;
   endfunction

   // idle pressure varies by window: none, light, heavy
   function automatic logic idle_now();
      case ((cycle_cnt / 256) % 3)
         0: return 1'b0;
         1: return ($urandom_range(0, 7) == 0);
         default: return ($urandom_range(0, 1) == 0);
      endcase
   endfunction

   task automatic queue_req(kind_type k, int pid, int h);
      req_word_type w;
      w.kind    = k;
      w.peer_id = pid[PID_W-1:0];
      w.handle  = h[HANDLE_W-1:0];
      req_backlog.push_back(w);
   endtask

   // fill the backlog: directed corner cases first, then a random mix
   initial begin
      req_word_type w;
      int           roll;
      for (int p = 0; p < PEERS_DEF; p++) begin
         peer_handle_tbl[p] = '0;
         peer_up[p]         = 1'b0;
      end
      for (int h = 0; h < HANDLES_DEF; h++) begin
         handle_mapped[h] = 1'b0;
         handle_owner[h]  = '0;
      end
      last_chosen = '0;

      queue_req(KIND_PICK, 0, 0);
      queue_req(KIND_GET, 0, 0);
      queue_req(KIND_BIND, 0, 77);
      queue_req(KIND_BIND, 1, 5);
      queue_req(KIND_BIND, 15, 1023);
      queue_req(KIND_BIND, 7, 0);
      queue_req(KIND_BIND, 3, 1024);
      queue_req(KIND_BIND, 4, 65535);
      queue_req(KIND_GET, 7, 0);
      queue_req(KIND_GET, 15, 0);
      queue_req(KIND_PICK, 0, 0);
      queue_req(KIND_PICK, 15, 65535);
      queue_req(KIND_PICK, 0, 0);
      queue_req(KIND_PICK, 0, 0);
      queue_req(KIND_PICK, 0, 0);
      queue_req(KIND_DOWN, 0, 0);
      queue_req(KIND_DOWN, 0, 65535);
      queue_req(KIND_DOWN, 0, 1024);
      queue_req(KIND_DOWN, 0, 900);
      queue_req(KIND_BIND, 1, 6);
      queue_req(KIND_DOWN, 0, 5);
      queue_req(KIND_GET, 1, 0);
      queue_req(KIND_DOWN, 0, 1023);
      queue_req(KIND_GET, 15, 0);
      queue_req(KIND_PICK, 0, 0);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) w.kind = KIND_BIND;
         else if (roll < 50) w.kind = KIND_DOWN;
         else if (roll < 70) w.kind = KIND_GET;
         else w.kind = KIND_PICK;
         w.peer_id = ($urandom_range(0, 9) == 0) ? PID_W'(0) : PID_W'($urandom_range(1, 15));
         // keep most handles in a small pool so bind and mark-down meet
         roll = $urandom_range(0, 99);
         if (roll < 70) w.handle = HANDLE_W'($urandom_range(1, 24));
         else if (roll < 78) w.handle = '0;
         else if (roll < 88) w.handle = HANDLE_W'($urandom_range(1, HANDLES_DEF - 1));
         else w.handle = HANDLE_W'($urandom_range(0, 65535));
         req_backlog.push_back(w);
      end
   end

   // drive request words, predict on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word  <= '0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            due_rsp.push_back(registry_apply(req_word));
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0 && !tail_quiet()) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (!tail_quiet() && idle_now()) begin
               req_gap = $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_word  <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // stall the result side in bursts
   always @(posedge clock) begin
      if (reset || tail_quiet()) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_now()) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted result word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsp.size() == 0) begin
            $display("%0t: result word %h with none expected", $time, rsp_word);
            fail_count++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_word.status !== want.status) begin
               $display("%0t: status expected %h actual %h",
                        $time, want.status, rsp_word.status);
               fail_count++;
            end
            if (rsp_word.chosen_peer !== want.chosen_peer) begin
               $display("%0t: chosen_peer expected %h actual %h",
                        $time, want.chosen_peer, rsp_word.chosen_peer);
               fail_count++;
            end
            if (rsp_word.peer_handle !== want.peer_handle) begin
               $display("%0t: peer_handle expected %h actual %h",
                        $time, want.peer_handle, rsp_word.peer_handle);
               fail_count++;
            end
         end
      end
   end

   // hard stop on a hung run
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // release reset, wait for the backlog to drain, then report
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_backlog.size() > 0 || req_valid || due_rsp.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
src/prrr_pkg.sv
src/peer_registry_round_robin.sv
tb/sv/peer_registry_round_robin_tb.sv
